// ===== rtl/psa_pkg.sv =====
`timescale 1ns / 1ps

package psa_pkg;

    localparam int SLOT_COUNT_DEFAULT = 128;

    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 8;
    localparam int TS_W     = 64;
    localparam int STATUS_W = 2;
    localparam int CNT64_W  = 64;
    localparam int WRAP_W   = 32;
    localparam int USED_W   = 8;

    // item kinds; unused codes behave as a read
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FREE    = 2'd3;

    // one slot's statistics as held in the slot memory
    typedef struct packed {
        logic              armed;
        logic [TS_W-1:0]   start_time;
        logic [CNT64_W-1:0] cost_sum;
        logic [CNT64_W-1:0] call_count;
        logic [WRAP_W-1:0] wrap_tally;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic diff;
        logic update;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
    } t_stat;

endpackage

// ===== rtl/psa_ctrl.sv =====
`timescale 1ns / 1ps

module psa_ctrl
    import psa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_DIFF   = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/psa_datapath.sv =====
`timescale 1ns / 1ps

module psa_datapath
    import psa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [TS_W-1:0]     i_timestamp,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot_index,
    output logic                o_slot_in_use,
    output logic [CNT64_W-1:0]  o_total_cycles,
    output logic [CNT64_W-1:0]  o_completed_calls,
    output logic [WRAP_W-1:0]   o_wrap_count,
    output logic [USED_W-1:0]   o_slots_in_use
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // slot statistics memory
    t_entry r_mem [SLOT_COUNT];
    t_entry r_rdata;

    logic            mem_wr;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;

    // occupancy flags and count
    logic [SLOT_COUNT-1:0] r_occ;
    logic [CW-1:0]         r_used;
    logic [CW-1:0]         n_used;
    logic                  occ_set;
    logic                  occ_clr;

    logic [AW-1:0]         r_clr_idx;

    // item registers
    logic [KIND_W-1:0]  r_kind;
    logic [SLOT_W-1:0]  r_slot;
    logic [TS_W-1:0]    r_ts;
    logic [TS_W-1:0]    r_diff;

    logic [AW-1:0]      slot_idx;
    logic               slot_ok;
    logic               free_found;
    logic [AW-1:0]      free_idx;
    logic [CNT64_W:0]   sum;

    // output registers
    logic                r_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [SLOT_W-1:0]   r_slot_index;
    logic [SLOT_W-1:0]   n_slot_index;
    logic                r_in_use;
    logic                n_in_use;
    t_entry              r_stats;
    t_entry              n_stats;

    assign slot_idx = AW'(r_slot);
    assign slot_ok  = (32'(r_slot) < SLOT_COUNT);
    assign o_stat.clear_last = (r_clr_idx == AW'(SLOT_COUNT - 1));

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    assign sum = {1'b0, r_rdata.cost_sum} + {1'b0, r_diff};

    always_comb begin
        mem_wr       = 1'b0;
        mem_waddr    = slot_idx;
        mem_wdata    = r_rdata;
        occ_set      = 1'b0;
        occ_clr      = 1'b0;
        n_used       = r_used;
        n_status     = STATUS_OK;
        n_slot_index = r_slot;
        n_in_use     = 1'b0;
        n_stats      = '0;

        if (i_cmd.clear_wr) begin
            mem_wr    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = '0;
        end else if (r_kind == KIND_ADD) begin
            if (free_found) begin
                mem_wr       = i_cmd.update;
                mem_waddr    = free_idx;
                mem_wdata    = '0;
                occ_set      = i_cmd.update;
                n_used       = r_used + CW'(1);
                n_slot_index = SLOT_W'(free_idx);
                n_in_use     = 1'b1;
            end else begin
                n_status     = STATUS_FULL;
                n_slot_index = '0;
            end
        end else if (!slot_ok) begin
            n_status = STATUS_INVALID;
        end else begin
            n_in_use = r_occ[slot_idx];
            case (r_kind)
                KIND_REMOVE: begin
                    if (r_occ[slot_idx]) begin
                        occ_clr  = i_cmd.update;
                        n_used   = r_used - CW'(1);
                        n_in_use = 1'b0;
                    end else begin
                        n_status = STATUS_FREE;
                    end
                end
                KIND_START: begin
                    mem_wr               = i_cmd.update;
                    mem_wdata.armed      = 1'b1;
                    mem_wdata.start_time = r_ts;
                end
                KIND_END: begin
                    if (r_rdata.armed) begin
                        mem_wr               = i_cmd.update;
                        mem_wdata.armed      = 1'b0;
                        mem_wdata.start_time = '0;
                        mem_wdata.cost_sum   = sum[CNT64_W-1:0];
                        mem_wdata.call_count = r_rdata.call_count + CNT64_W'(1);
                        if (sum[CNT64_W] && (r_rdata.wrap_tally != '1)) begin
                            mem_wdata.wrap_tally = r_rdata.wrap_tally + WRAP_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
            n_stats = mem_wdata;
        end
    end

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.load) begin
            r_rdata <= r_mem[AW'(i_slot)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_slot <= i_slot;
            r_ts   <= i_timestamp;
        end
        if (i_cmd.diff) begin
            r_diff <= r_ts - r_rdata.start_time;
        end
        if (i_cmd.update) begin
            r_status     <= n_status;
            r_slot_index <= n_slot_index;
            r_in_use     <= n_in_use;
            r_stats      <= n_stats;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_used    <= '0;
            r_clr_idx <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.update;
            if (i_cmd.clear_wr) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (occ_set) begin
                r_occ[free_idx] <= 1'b1;
            end
            if (occ_clr) begin
                r_occ[slot_idx] <= 1'b0;
            end
            if (i_cmd.update) begin
                r_used <= n_used;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_slot_index      = r_slot_index;
    assign o_slot_in_use     = r_in_use;
    assign o_total_cycles    = r_stats.cost_sum;
    assign o_completed_calls = r_stats.call_count;
    assign o_wrap_count      = r_stats.wrap_tally;
    assign o_slots_in_use    = USED_W'(r_used);

endmodule

// ===== rtl/profiling_slot_accumulator.sv =====
`timescale 1ns / 1ps

// Profiling slot table. Raise start with an item while busy is low; the
// item is taken at that edge. Its single result appears on the o_ result
// ports for exactly one cycle, marked by o_valid, after the difference and
// update states. There is no way to hold a result off: capture it in the
// o_valid cycle. busy drops in that same cycle, so a new item is taken
// only once the last is through the slot memory read, the 64-bit
// timestamp difference, and the add, wrap check and write-back.
// After reset busy stays high while the slot memory is swept to zero,
// one slot per cycle.
module profiling_slot_accumulator
    import psa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [TS_W-1:0]     i_timestamp,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot_index,
    output logic                o_slot_in_use,
    output logic [CNT64_W-1:0]  o_total_cycles,
    output logic [CNT64_W-1:0]  o_completed_calls,
    output logic [WRAP_W-1:0]   o_wrap_count,
    output logic [USED_W-1:0]   o_slots_in_use
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: clear sweep, idle, difference, update
    psa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // slot memory, occupancy flags, arithmetic and result registers
    psa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_kind            (i_kind),
        .i_slot            (i_slot),
        .i_timestamp       (i_timestamp),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_slot_index      (o_slot_index),
        .o_slot_in_use     (o_slot_in_use),
        .o_total_cycles    (o_total_cycles),
        .o_completed_calls (o_completed_calls),
        .o_wrap_count      (o_wrap_count),
        .o_slots_in_use    (o_slots_in_use)
    );

endmodule
